// ===== hw/rtl/kvcp_pkg.sv =====
package kvcp_pkg;

  localparam int unsigned NumKeys = 22;

  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEqual = 8'h3d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;

  localparam logic [7:0] KeyTable [NumKeys] = '{
    8'h61, 8'h69, 8'h49, 8'h70, 8'h66, 8'h74, 8'h6d, 8'h6f, 8'h73, 8'h76, 8'h78,
    8'h79, 8'h77, 8'h68, 8'h63, 8'h72, 8'h58, 8'h59, 8'h7a, 8'h43, 8'h71, 8'h64
  };

  typedef enum logic [2:0] {
    PH_BETWEEN   = 3'd0,
    PH_AFTER_KEY = 3'd1,
    PH_VALUE     = 3'd2,
    PH_PAYLOAD   = 3'd3,
    PH_FAILED    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    NP_WS     = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_STOP   = 2'd3
  } num_phase_e;

  typedef enum logic [1:0] {
    KIND_PAIR    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_OK      = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  key_slot;
    logic [31:0] number;
    logic [7:0]  first_char;
    logic [7:0]  payload_byte;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic       known;
    logic [4:0] slot;
  } key_hit_t;

  function automatic key_hit_t key_lookup(input logic [7:0] c);
    key_hit_t hit;
    hit = '0;
    for (int unsigned i = 0; i < NumKeys; i++) begin
      if (KeyTable[i] == c) begin
        hit.known = 1'b1;
        hit.slot  = 5'(i);
      end
    end
    return hit;
  endfunction

endpackage

// ===== hw/rtl/key_value_command_parser.sv =====
// channel  dir  tdata                                        tuser  tlast
// s_axis   in   [7:0] in_byte                                -      last_byte
// m_axis   out  [4:0] key_slot, [36:5] number,               kind   run_end
//               [44:37] first_char, [52:45] payload_byte
//
// one byte per cycle while the queue has room: parser state updates on the
// accepting edge and up to two results enter the four-entry queue at that same edge
// the number update is a times-ten shift-add with the sign folded in
// an item with two results drains as two output transfers; input stalls
// only while fewer than two queue entries are free
// reset puts the parser between pairs and empties the queue
module key_value_command_parser #(
  parameter int unsigned MAX_VALUE_CHARS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // in_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // key_slot, number, first_char, payload_byte
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // run_end
);

  kvcp_pkg::push_t   push;
  kvcp_pkg::result_t head;
  logic              accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  kvcp_parser #(
    .MAX_VALUE_CHARS(MAX_VALUE_CHARS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .push_o   (push)
  );

  kvcp_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {3'b000, head.payload_byte, head.first_char, head.number,
                           head.key_slot};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.run_end;

endmodule

// ===== hw/rtl/kvcp_parser.sv =====
module kvcp_parser #(
  parameter int unsigned MAX_VALUE_CHARS = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output kvcp_pkg::push_t   push_o
);

  localparam int unsigned CntW = $clog2(MAX_VALUE_CHARS + 1);

  kvcp_pkg::phase_e     phase_q, phase_d;
  kvcp_pkg::num_phase_e np_q, np_d;
  logic [4:0]           key_q, key_d;
  logic                 known_q, known_d;
  logic [31:0]          num_q, num_d;
  logic                 neg_q, neg_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [7:0]           fchar_q, fchar_d;

  kvcp_pkg::key_hit_t   hit;
  kvcp_pkg::result_t    main_res, end_res;
  logic                 has_main, fail;
  logic                 is_digit, is_ws, is_sign;
  logic [31:0]          num_x10, num_step, digit;

  assign hit      = kvcp_pkg::key_lookup(byte_i);
  assign is_digit = (byte_i >= kvcp_pkg::ChZero) && (byte_i <= kvcp_pkg::ChNine);
  assign is_ws    = (byte_i == kvcp_pkg::ChSpace) ||
                    ((byte_i >= kvcp_pkg::ChTab) && (byte_i <= kvcp_pkg::ChCr));
  assign is_sign  = (byte_i == kvcp_pkg::ChPlus) || (byte_i == kvcp_pkg::ChMinus);
  assign digit    = {28'b0, byte_i[3:0]};

  // the sign is folded in as digits arrive: -(10a + d) = 10(-a) - d
  assign num_x10  = {num_q[28:0], 3'b000} + {num_q[30:0], 1'b0};
  assign num_step = neg_q ? (num_x10 - digit) : (num_x10 + digit);

  always_comb begin
    phase_d  = phase_q;
    np_d     = np_q;
    key_d    = key_q;
    known_d  = known_q;
    num_d    = num_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    fchar_d  = fchar_q;
    fail     = 1'b0;
    has_main = 1'b0;
    main_res = '0;

    unique case (phase_q)
      kvcp_pkg::PH_BETWEEN: begin
        if (byte_i == kvcp_pkg::ChSemi) begin
          phase_d = kvcp_pkg::PH_PAYLOAD;
        end else if ((byte_i != kvcp_pkg::ChComma) && (byte_i != kvcp_pkg::ChSpace)) begin
          known_d = hit.known;
          key_d   = hit.slot;
          phase_d = kvcp_pkg::PH_AFTER_KEY;
          fail    = last_i;
        end
      end
      kvcp_pkg::PH_AFTER_KEY: begin
        if (byte_i == kvcp_pkg::ChEqual) begin
          num_d   = '0;
          neg_d   = 1'b0;
          np_d    = kvcp_pkg::NP_WS;
          cnt_d   = '0;
          fchar_d = '0;
          phase_d = kvcp_pkg::PH_VALUE;
        end else begin
          phase_d = kvcp_pkg::PH_FAILED;
          fail    = 1'b1;
        end
      end
      kvcp_pkg::PH_VALUE: begin
        if ((byte_i == kvcp_pkg::ChComma) || (byte_i == kvcp_pkg::ChSemi)) begin
          has_main = 1'b1;
          phase_d  = (byte_i == kvcp_pkg::ChSemi) ? kvcp_pkg::PH_PAYLOAD
                                                  : kvcp_pkg::PH_BETWEEN;
        end else begin
          if (cnt_q < CntW'(MAX_VALUE_CHARS)) begin
            if (cnt_q == '0) begin
              fchar_d = byte_i;
            end
            cnt_d = cnt_q + CntW'(1);
            if ((np_q == kvcp_pkg::NP_WS) && is_ws) begin
              np_d = np_q;
            end else if ((np_q == kvcp_pkg::NP_WS) && is_sign) begin
              neg_d = (byte_i == kvcp_pkg::ChMinus);
              np_d  = kvcp_pkg::NP_SIGN;
            end else if (np_q == kvcp_pkg::NP_STOP) begin
              np_d = np_q;
            end else if (is_digit) begin
              num_d = num_step;
              np_d  = kvcp_pkg::NP_DIGITS;
            end else begin
              np_d = kvcp_pkg::NP_STOP;
            end
          end
          has_main = last_i;
        end
        has_main = has_main && known_q && (cnt_d != '0);
        main_res.kind       = kvcp_pkg::KIND_PAIR;
        main_res.key_slot   = key_q;
        main_res.number     = num_d;
        main_res.first_char = fchar_d;
      end
      kvcp_pkg::PH_PAYLOAD: begin
        has_main              = 1'b1;
        main_res.kind         = kvcp_pkg::KIND_PAYLOAD;
        main_res.payload_byte = byte_i;
      end
      kvcp_pkg::PH_FAILED: begin
        fail = 1'b1;
      end
      default: begin
        phase_d = kvcp_pkg::PH_BETWEEN;
      end
    endcase

    main_res.run_end = !last_i;
    end_res          = '0;
    end_res.kind     = fail ? kvcp_pkg::KIND_FAIL : kvcp_pkg::KIND_OK;
    end_res.run_end  = 1'b1;

    push_o = '0;
    if (accept_i) begin
      push_o.n  = {1'b0, has_main} + {1'b0, last_i};
      push_o.r0 = has_main ? main_res : end_res;
      push_o.r1 = end_res;
    end

    // end of command returns to the idle state
    if (last_i) begin
      phase_d = kvcp_pkg::PH_BETWEEN;
      key_d   = '0;
      known_d = 1'b0;
      num_d   = '0;
      neg_d   = 1'b0;
      np_d    = kvcp_pkg::NP_WS;
      cnt_d   = '0;
      fchar_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kvcp_pkg::PH_BETWEEN;
      np_q    <= kvcp_pkg::NP_WS;
      key_q   <= '0;
      known_q <= 1'b0;
      num_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      fchar_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      np_q    <= np_d;
      key_q   <= key_d;
      known_q <= known_d;
      num_q   <= num_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      fchar_q <= fchar_d;
    end
  end

endmodule

// ===== hw/rtl/kvcp_result_queue.sv =====
module kvcp_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kvcp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output kvcp_pkg::result_t head_o
);

  localparam int unsigned Depth = 4;

  kvcp_pkg::result_t entry_q [Depth];
  kvcp_pkg::result_t entry_d [Depth];
  logic [2:0]        count_q, count_d;
  logic [2:0]        base;
  logic              pop;

  assign valid_o = (count_q != 3'd0);
  assign room_o  = (count_q <= 3'd2);
  assign head_o  = entry_q[0];
  assign pop     = valid_o && ready_i;
  assign base    = count_q - {2'b00, pop};

  // shift register queue, head always at entry zero
  always_comb begin
    for (int unsigned j = 0; j < Depth; j++) begin
      if (pop && (j < Depth - 1)) begin
        entry_d[j] = entry_q[j+1];
      end else begin
        entry_d[j] = entry_q[j];
      end
      if ((push_i.n != 2'd0) && (3'(j) == base)) begin
        entry_d[j] = push_i.r0;
      end
      if ((push_i.n == 2'd2) && (3'(j) == base + 3'd1)) begin
        entry_d[j] = push_i.r1;
      end
    end
    count_d = base + {1'b0, push_i.n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned j = 0; j < Depth; j++) begin
      entry_q[j] <= entry_d[j];
    end
  end

endmodule
